### hdl/stptp_pkg.sv
package stptp_pkg;

    // Result codes reported with each word
    typedef logic [2:0] t_event;

    localparam t_event EV_NONE     = 3'd0;
    localparam t_event EV_BEGUN    = 3'd1;
    localparam t_event EV_ENDED    = 3'd2;
    localparam t_event EV_SENT     = 3'd3;
    localparam t_event EV_REJECTED = 3'd4;
    localparam t_event EV_OVERFLOW = 3'd5;

    // Item kinds carried in tuser
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Command characters
    localparam logic [7:0] CH_BEGIN = 8'h42;  // 'B'
    localparam logic [7:0] CH_END   = 8'h45;  // 'E'
    localparam logic [7:0] CH_LOW   = 8'h4C;  // 'L'
    localparam logic [7:0] CH_HIGH  = 8'h48;  // 'H'
    localparam logic [7:0] CH_STORE = 8'h3B;  // ';'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Result word layout
    localparam int OUT_BYTES = 1;

endpackage

### hdl/stptp_ram.sv
module stptp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port (read returns old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/serial_text_pulse_train_player_core.sv
// Serial text pulse train player. Each input word is either a received ASCII character
// (tuser = 0) or a one-microsecond tick (tuser = 1), and every accepted word yields exactly
// one registered result word. The block takes one word per cycle, back to back; the
// result sits in a two-entry output buffer, so tready only drops when both entries are
// full. Durations live in one single-port-write, registered-read RAM of DEPTH entries;
// the RAM is read every cycle at the next read pointer and a same-entry write is forwarded,
// so the entry at the read pointer is always ready and no tick waits for memory. The RAM is
// not cleared after reset and needs no clearing pass: playback only reads entries that
// were stored since the frame opened.
module serial_text_pulse_train_player_core #(
    parameter int DEPTH         = 256,
    parameter int DURATION_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_code
    input  logic [0:0] i_s_axis_tuser,   // [0] kind
    // result stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [stptp_pkg::OUT_BYTES*8-1:0] o_m_axis_tdata
    // o_m_axis_tdata: [0] pin_level, [3:1] event_res, [4] receiver_enable,
    //                 [5] busy_res, [7:6] zero
);

    import stptp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int DB = DURATION_BITS;
    localparam int OW = OUT_BYTES * 8;

    // Architectural state
    logic [PW-1:0] r_read_ptr,  n_read_ptr;
    logic [PW-1:0] r_write_ptr, n_write_ptr;
    logic [PW-1:0] r_fill_ptr,  n_fill_ptr;
    logic [DB-1:0] r_number_acc, n_number_acc;
    logic [DB-1:0] r_countdown,  n_countdown;
    logic          r_level,   n_level;
    logic          r_started, n_started;
    logic          r_rx_on,   n_rx_on;
    logic          r_reload,  n_reload;   // countdown is due to load from the entry at read_ptr

    // Forwarding of a write that hit the entry being read
    logic          r_fwd;
    logic [DB-1:0] r_fwd_data;

    // Output buffer
    logic          r_out_valid, r_skid_valid;
    logic [OW-1:0] r_out_data,  r_skid_data;

    logic          in_fire, out_fire;
    logic          busy, busy_after;
    logic          ram_we;
    logic [DB-1:0] ram_rdata, cur_entry, cur_dur, cd_eff, cd_dec;
    logic [PW-1:0] rp_next, fp_next;
    logic [DB+3:0] acc_ext, acc_mul;
    logic [7:0]    ch;
    t_event        ev;
    logic [OW-1:0] result;

    function automatic logic [PW-1:0] next_index(input logic [PW-1:0] p);
        next_index = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_s_axis_tready = !r_skid_valid;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = r_out_valid && i_m_axis_tready;

    assign ch   = i_s_axis_tdata;
    assign busy = (r_read_ptr != r_write_ptr);

    // Duration RAM, read every cycle at the next read pointer
    stptp_ram #(
        .WIDTH (DB),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill_ptr),
        .i_wdata (r_number_acc),
        .i_raddr (n_read_ptr),
        .o_rdata (ram_rdata)
    );

    assign cur_entry = r_fwd ? r_fwd_data : ram_rdata;
    assign cur_dur   = (cur_entry == '0) ? DB'(1) : cur_entry;
    assign cd_eff    = r_reload ? cur_dur : r_countdown;
    assign cd_dec    = cd_eff - 1'b1;
    assign rp_next   = next_index(r_read_ptr);
    assign fp_next   = next_index(r_fill_ptr);

    // Decimal accumulate: acc*10 + digit, saturated at all ones below
    assign acc_ext = {4'b0, r_number_acc};
    assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + {{DB{1'b0}}, ch[3:0]};

    // Item processing
    always_comb begin
        n_read_ptr   = r_read_ptr;
        n_write_ptr  = r_write_ptr;
        n_fill_ptr   = r_fill_ptr;
        n_number_acc = r_number_acc;
        n_countdown  = r_countdown;
        n_level      = r_level;
        n_started    = r_started;
        n_rx_on      = r_rx_on;
        n_reload     = r_reload;
        ram_we       = 1'b0;
        ev           = EV_NONE;

        if (in_fire) begin
            if (i_s_axis_tuser[0] == KIND_CHAR) begin
                if (busy) begin
                    ev = EV_REJECTED;
                end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
                    if (acc_mul > {4'b0, {DB{1'b1}}}) begin
                        n_number_acc = {DB{1'b1}};
                    end else begin
                        n_number_acc = acc_mul[DB-1:0];
                    end
                end else begin
                    case (ch)
                        CH_BEGIN: begin
                            n_fill_ptr = r_read_ptr;
                            n_rx_on    = 1'b0;
                            ev         = EV_BEGUN;
                        end
                        CH_LOW, CH_HIGH: begin
                            n_number_acc = '0;
                        end
                        CH_STORE: begin
                            if (fp_next == r_read_ptr) begin
                                ev = EV_OVERFLOW;
                            end else begin
                                ram_we     = 1'b1;
                                n_fill_ptr = fp_next;
                            end
                            n_number_acc = '0;
                        end
                        CH_END: begin
                            n_write_ptr = r_fill_ptr;
                            n_started   = 1'b0;
                            n_reload    = 1'b0;
                            n_countdown = '0;
                            if (r_fill_ptr == r_read_ptr) begin
                                n_rx_on = 1'b1;
                            end
                            ev = EV_ENDED;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (busy) begin
                if (!r_started) begin
                    // first tick: low level, duration loads from the current entry
                    n_started = 1'b1;
                    n_level   = 1'b0;
                    n_reload  = 1'b1;
                end else if (cd_dec != '0) begin
                    n_countdown = cd_dec;
                    n_reload    = 1'b0;
                end else begin
                    n_countdown = '0;
                    n_read_ptr  = rp_next;
                    if (rp_next == r_write_ptr) begin
                        n_level   = 1'b0;
                        n_rx_on   = 1'b1;
                        n_started = 1'b0;
                        n_reload  = 1'b0;
                        ev        = EV_SENT;
                    end else begin
                        // next entry is in the RAM read register by the next tick
                        n_level  = !r_level;
                        n_reload = 1'b1;
                    end
                end
            end
        end
    end

    assign busy_after = (n_read_ptr != n_write_ptr);
    assign result = {{(OW-6){1'b0}}, busy_after, n_rx_on, ev, n_level};

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_ptr   <= '0;
            r_write_ptr  <= '0;
            r_fill_ptr   <= '0;
            r_number_acc <= '0;
            r_countdown  <= '0;
            r_level      <= 1'b0;
            r_started    <= 1'b0;
            r_rx_on      <= 1'b1;
            r_reload     <= 1'b0;
            r_fwd        <= 1'b0;
        end else begin
            r_read_ptr   <= n_read_ptr;
            r_write_ptr  <= n_write_ptr;
            r_fill_ptr   <= n_fill_ptr;
            r_number_acc <= n_number_acc;
            r_countdown  <= n_countdown;
            r_level      <= n_level;
            r_started    <= n_started;
            r_rx_on      <= n_rx_on;
            r_reload     <= n_reload;
            r_fwd        <= ram_we && (r_fill_ptr == n_read_ptr);
        end
    end

    // Forward data for a write that collides with the read
    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_fwd_data <= r_number_acc;
        end
    end

    // Two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!in_fire) begin
                r_out_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_fire) begin
                r_out_data <= result;
            end
        end else if (in_fire) begin
            if (!r_out_valid) begin
                r_out_data <= result;
            end else begin
                r_skid_data <= result;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // skid entry is only used behind a held output word
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output word");

    // no store into the ring while a train is playing
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !busy)
        else $error("duration store written during playback");

    // a pending reload only exists inside a started train
    a_reload_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reload |-> (r_started && busy))
        else $error("countdown reload pending outside playback");
`endif

endmodule
